>>> sv/mgfb_pkg.sv
// Shared widths, defaults and elaboration-time coefficient math for the Gaussian filter bank.
package mgfb_pkg;

  localparam int SENSOR_W    = 2;
  localparam int SAMPLE_W    = 16;
  localparam int SCALE_IDX_W = 4;
  localparam int COEF_W      = 18;
  localparam int FRAC_W      = 17;
  localparam int PROD_W      = COEF_W + SAMPLE_W;

  localparam int DEF_NUM_GROUPS       = 4;
  localparam int DEF_LAYERS_PER_GROUP = 2;
  localparam int DEF_NUM_SENSORS      = 4;
  localparam int DEF_TAPS             = 256;

  localparam logic [63:0] Q30_ONE   = 64'd1073741824;
  localparam logic [63:0] Q30_MASK  = 64'd1073741823;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
  localparam logic [63:0] COEF_MAX  = 64'd262143;

  // Restoring division for narrow values.
  function automatic logic [31:0] udiv32(input logic [31:0] n, input logic [31:0] dv);
    logic [32:0] rem;
    logic [31:0] q;
    rem = '0;
    q   = '0;
    for (int i = 31; i >= 0; i--) begin
      rem = {rem[31:0], n[i]};
      q   = {q[30:0], 1'b0};
      if (rem >= {1'b0, dv}) begin
        rem  = rem - {1'b0, dv};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, dv}) begin
        rem  = rem - {1'b0, dv};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^-f for a Q30 fraction, by a truncated Taylor series of exp(-f*ln2).
  function automatic logic [63:0] exp2neg_frac(input logic [63:0] f);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    t    = ((f & Q30_MASK) * LN2_Q30) >> 30;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= 13; k++) begin
      term = 64'(udiv32(32'((term * t) >> 30), 32'(k)));
      if (k[0]) sum = sum - term;
      else      sum = sum + term;
    end
    return sum;
  endfunction

  // Exponent slope log2(e) * 2^-(2l/(L+1)) in Q30 for one layer.
  function automatic logic [63:0] sigma_x1(input int unsigned l, input int unsigned layers);
    logic [63:0] e;
    logic [63:0] m;
    e = udiv64(64'(2 * l) << 30, 64'(layers + 1));
    m = exp2neg_frac(e & Q30_MASK) >> (e >> 30);
    return (m * LOG2E_Q30) >> 30;
  endfunction

  // Gaussian weight in Q20 for tap offset d of group g.
  function automatic logic [31:0] gauss_weight(input logic [63:0] d, input logic [63:0] x1,
                                               input int unsigned g);
    logic [63:0] xq;
    logic [63:0] n;
    logic [63:0] w30;
    xq = (d * d * x1) >> (2 * g + 3);
    n  = xq >> 30;
    if (n >= 64'd31) w30 = '0;
    else             w30 = exp2neg_frac(xq & Q30_MASK) >> n;
    return 32'((w30 + 64'd512) >> 10);
  endfunction

  // round(a*b/c), half up, saturating to all ones.
  function automatic logic [63:0] mul_div_round(input logic [63:0] a, input logic [63:0] b,
                                                input logic [63:0] c);
    logic [127:0] num;
    logic [64:0]  rem;
    logic [127:0] q;
    if (c == '0) return '1;
    num = 128'(a) * 128'(b) + 128'(c >> 1);
    rem = '0;
    q   = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      q   = {q[126:0], 1'b0};
      if (rem >= {1'b0, c}) begin
        rem  = rem - {1'b0, c};
        q[0] = 1'b1;
      end
    end
    return (|q[127:64]) ? '1 : q[63:0];
  endfunction

endpackage

>>> sv/mgfb_ifs.sv
// Valid/ready channel interfaces for the input samples and the filtered results.
interface mgfb_in_if;
  import mgfb_pkg::*;

  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor;
  logic [SAMPLE_W-1:0] sample_value;

  modport source(output valid, output sensor, output sample_value, input ready);
  modport sink(input valid, input sensor, input sample_value, output ready);
endinterface

interface mgfb_out_if;
  import mgfb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SCALE_IDX_W-1:0] scale_index;
  logic [SENSOR_W-1:0]    sensor_of_result;
  logic [SAMPLE_W-1:0]    smoothed_value;
  logic                   last_of_run;

  modport source(output valid, output scale_index, output sensor_of_result,
                 output smoothed_value, output last_of_run, input ready);
  modport sink(input valid, input scale_index, input sensor_of_result,
               input smoothed_value, input last_of_run, output ready);
endinterface

>>> sv/multiscale_gaussian_fir_bank.sv
// Top level of the multiscale Gaussian FIR bank: delay lines, shared MAC and sequencer.
//
// Channel    Role     Payload of one word
// in_chan    sink     sensor, sample_value
// out_chan   source   scale_index, sensor_of_result, smoothed_value, last_of_run
//
// A word for a valid sensor is filtered in the one shared multiply-accumulate unit,
// which walks TAPS taps per scale; after each scale's last tap the ROM/memory read
// and multiplier registers drain before the result is handed over.
// A word for a sensor at or above NUM_SENSORS is taken and gives no results.
// Reset is synchronous; the delay lines start as zeros through per-sensor fill flags,
// so no clearing pass is needed. A result waiting in the output register holds the
// sequencer only when the next scale's result is ready to be loaded.
module multiscale_gaussian_fir_bank #(
  parameter int NUM_GROUPS       = mgfb_pkg::DEF_NUM_GROUPS,
  parameter int LAYERS_PER_GROUP = mgfb_pkg::DEF_LAYERS_PER_GROUP,
  parameter int NUM_SENSORS      = mgfb_pkg::DEF_NUM_SENSORS,
  parameter int TAPS             = mgfb_pkg::DEF_TAPS
) (
  input  logic        clk,
  input  logic        rst_n,
  mgfb_in_if.sink     in_chan,
  mgfb_out_if.source  out_chan
);
  import mgfb_pkg::*;

  localparam int NUM_SCALES = NUM_GROUPS * (LAYERS_PER_GROUP + 1);
  localparam int ROM_D      = NUM_SCALES * TAPS;
  localparam int CADDR_W    = $clog2(ROM_D);
  localparam int MEM_D      = NUM_SENSORS * TAPS;
  localparam int MADDR_W    = $clog2(MEM_D);
  localparam int TAP_W      = $clog2(TAPS);
  localparam int SENS_W     = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int SCALE_W    = (NUM_SCALES > 1) ? $clog2(NUM_SCALES) : 1;
  localparam int ACC_W      = PROD_W + $clog2(TAPS);
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;

  state_t                 state_r;

  // Per-sensor ring bookkeeping. A slot reads as zero until the ring has wrapped
  // once or the slot lies at or below the current write position.
  logic [TAP_W-1:0]       pos_arr_r  [NUM_SENSORS];
  logic                   full_arr_r [NUM_SENSORS];

  // The delay lines of all sensors share one memory, one sensor per TAPS slots.
  logic [SAMPLE_W-1:0]    delay_mem [MEM_D];

  // Context of the word being filtered.
  logic [SENSOR_W-1:0]    sensor_r;
  logic [TAP_W-1:0]       pos_r;
  logic                   full_r;
  logic [MADDR_W-1:0]     base_r;
  logic [TAP_W-1:0]       idx_r;
  logic [TAP_W-1:0]       tap_cnt_r;
  logic [CADDR_W-1:0]     coef_addr_r;
  logic [SCALE_W-1:0]     scale_r;

  // MAC pipeline: read stage, multiply stage, accumulate.
  logic                   v1_r;
  logic                   live1_r;
  logic                   v2_r;
  logic [SAMPLE_W-1:0]    mem_q_r;
  logic [COEF_W-1:0]      coef_q;
  logic [PROD_W-1:0]      prod_r;
  logic [ACC_W-1:0]       acc_r;

  // Output register.
  logic                   out_valid_r;
  logic [SCALE_IDX_W-1:0] out_scale_r;
  logic [SENSOR_W-1:0]    out_sensor_r;
  logic [SAMPLE_W-1:0]    out_value_r;
  logic                   out_last_r;

  logic                   accept;
  logic                   sensor_ok;
  logic                   start;
  logic [SENS_W-1:0]      sn_idx;
  logic [TAP_W-1:0]       pos_in;
  logic [MADDR_W-1:0]     base_nxt;
  logic [MADDR_W-1:0]     wr_addr;
  logic [MADDR_W-1:0]     rd_addr;
  logic                   issue;
  logic                   live;
  logic                   slot_free;
  logic                   done_scale;
  logic                   scale_last;
  logic [ACC_W:0]         rnd;
  logic                   sat;
  logic [SAMPLE_W-1:0]    y_val;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign sensor_ok     = int'(in_chan.sensor) < NUM_SENSORS;
  assign start         = accept && sensor_ok;
  assign sn_idx        = SENS_W'(in_chan.sensor);
  assign pos_in        = pos_arr_r[sn_idx];
  assign base_nxt      = MADDR_W'(sn_idx) * MADDR_W'(TAPS);
  assign wr_addr       = base_nxt + MADDR_W'(pos_in);
  assign rd_addr       = base_r + MADDR_W'(idx_r);
  assign issue         = (state_r == ST_RUN);
  assign live          = full_r || (idx_r <= pos_r);

  assign slot_free  = !out_valid_r || out_chan.ready;
  assign done_scale = (state_r == ST_FINISH) && !v1_r && !v2_r && slot_free;
  assign scale_last = (scale_r == SCALE_W'(NUM_SCALES - 1));

  // Round to nearest at bit FRAC_W, then clamp to the sample range.
  assign rnd   = {1'b0, acc_r} + (ACC_W + 1)'(ROUND_HALF);
  assign sat   = |rnd[ACC_W:FRAC_W+SAMPLE_W];
  assign y_val = sat ? '1 : rnd[FRAC_W+SAMPLE_W-1:FRAC_W];

  mgfb_coef_rom #(
    .NUM_GROUPS      (NUM_GROUPS),
    .LAYERS_PER_GROUP(LAYERS_PER_GROUP),
    .TAPS            (TAPS)
  ) u_coef_rom (
    .clk    (clk),
    .rd_en  (issue),
    .rd_addr(coef_addr_r),
    .rd_data(coef_q)
  );

  // Sequencer. IDLE takes a word and writes its sample into the ring. RUN issues one
  // tap per cycle, newest sample first, with the ROM address simply counting through
  // all scales in order. FINISH waits for the MAC to drain and for the output
  // register to be free, hands over the result, then runs the next scale or goes idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      tap_cnt_r   <= '0;
      coef_addr_r <= '0;
      scale_r     <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        pos_arr_r[i]  <= '0;
        full_arr_r[i] <= 1'b0;
      end
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      // A new result loaded in the same cycle keeps the register valid.
      if (out_chan.valid && out_chan.ready && !done_scale) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_RUN;
            if (pos_in == TAP_W'(TAPS - 1)) begin
              pos_arr_r[sn_idx]  <= '0;
              full_arr_r[sn_idx] <= 1'b1;
            end else begin
              pos_arr_r[sn_idx]  <= pos_in + 1'b1;
            end
            sensor_r    <= in_chan.sensor;
            pos_r       <= pos_in;
            full_r      <= full_arr_r[sn_idx];
            base_r      <= base_nxt;
            idx_r       <= pos_in;
            tap_cnt_r   <= '0;
            coef_addr_r <= '0;
            scale_r     <= '0;
          end
        end
        ST_RUN: begin
          idx_r       <= (idx_r == '0) ? TAP_W'(TAPS - 1) : idx_r - 1'b1;
          tap_cnt_r   <= tap_cnt_r + 1'b1;
          coef_addr_r <= coef_addr_r + 1'b1;
          if (tap_cnt_r == TAP_W'(TAPS - 1)) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (done_scale) begin
            out_valid_r  <= 1'b1;
            out_scale_r  <= SCALE_IDX_W'(scale_r);
            out_sensor_r <= sensor_r;
            out_value_r  <= y_val;
            out_last_r   <= scale_last;
            if (scale_last) begin
              state_r <= ST_IDLE;
            end else begin
              state_r   <= ST_RUN;
              scale_r   <= scale_r + 1'b1;
              idx_r     <= pos_r;
              tap_cnt_r <= '0;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Delay memory and MAC datapath. Slots never written since reset are masked to zero.
  always_ff @(posedge clk) begin
    if (start) begin
      delay_mem[wr_addr] <= in_chan.sample_value;
    end
    if (issue) begin
      mem_q_r <= delay_mem[rd_addr];
    end
    live1_r <= live;
    prod_r  <= coef_q * (live1_r ? mem_q_r : '0);
  end

  // The accumulator starts each scale at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (start || done_scale) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.scale_index      = out_scale_r;
  assign out_chan.sensor_of_result = out_sensor_r;
  assign out_chan.smoothed_value   = out_value_r;
  assign out_chan.last_of_run      = out_last_r;

`ifndef SYNTHESIS
  a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (!v1_r && !v2_r))
    else $error("input taken while the MAC pipeline still holds taps");

  a_rom_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (int'(coef_addr_r) < ROM_D))
    else $error("coefficient address beyond the ROM");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == ST_RUN && tap_cnt_r == '0 && acc_r == '0))
    else $error("scale did not start from a clean accumulator");

  a_last_is_top_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last_of_run) |->
      (out_chan.scale_index == SCALE_IDX_W'(NUM_SCALES - 1)))
    else $error("last flag on a scale other than the final one");

  a_rescan_from_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && $past(state_r) == ST_FINISH) |-> (idx_r == pos_r))
    else $error("next scale does not start at the newest sample");
`endif

endmodule

>>> sv/mgfb_coef_rom.sv
// Coefficient ROM of all scales, built at elaboration, with a registered read port.
module mgfb_coef_rom #(
  parameter int NUM_GROUPS       = mgfb_pkg::DEF_NUM_GROUPS,
  parameter int LAYERS_PER_GROUP = mgfb_pkg::DEF_LAYERS_PER_GROUP,
  parameter int TAPS             = mgfb_pkg::DEF_TAPS
) (
  input  logic                                                         clk,
  input  logic                                                         rd_en,
  input  logic [$clog2(NUM_GROUPS*(LAYERS_PER_GROUP+1)*TAPS)-1:0]      rd_addr,
  output logic [mgfb_pkg::COEF_W-1:0]                                  rd_data
);
  import mgfb_pkg::*;

  localparam int NUM_SCALES = NUM_GROUPS * (LAYERS_PER_GROUP + 1);
  localparam int ROM_D      = NUM_SCALES * TAPS;
  localparam int CTR        = TAPS / 2;

  typedef logic [COEF_W-1:0] rom_t [ROM_D];

  // Kernels are normalized by their ideal sum and tuned by the stored-sum ratio
  // against the first scale, so every scale has the same gain as scale zero.
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [31:0] kern [TAPS];
    logic [63:0] s0;
    logic [63:0] t0;
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] x1;
    logic [63:0] v;
    logic [31:0] w;
    int          sc;
    s0 = '0;
    t0 = '0;
    sc = 0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int l = 0; l <= LAYERS_PER_GROUP; l++) begin
        x1 = sigma_x1(l, LAYERS_PER_GROUP);
        s  = '0;
        t  = '0;
        for (int d = 0; d <= CTR; d++) begin
          w = gauss_weight(64'(d), x1, g);
          if (d == 0) begin
            kern[CTR] = w;
            s = s + 64'(w);
          end else begin
            if (CTR + d < TAPS) kern[CTR + d] = w;
            kern[CTR - d] = w;
            s = s + (64'(w) << 1);
          end
        end
        for (int k = 0; k < TAPS; k++) t = t + 64'(kern[k]);
        if (sc == 0) begin
          s0 = s;
          t0 = t;
        end
        for (int k = 0; k < TAPS; k++) begin
          v = mul_div_round(64'(kern[k]) << 17, t0, s0 * t);
          rom[sc * TAPS + k] = (v > COEF_MAX) ? COEF_MAX[COEF_W-1:0] : v[COEF_W-1:0];
        end
        sc++;
      end
    end
    return rom;
  endfunction

  localparam rom_t COEF_ROM = build_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= COEF_ROM[rd_addr];
    end
  end

endmodule
